@@ rtl/core/swbd_pkg.sv @@
// Shared types and constants for the scope waveform block deframer.
`timescale 1ns / 1ps

package swbd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_SIZE = 3'd2,
        PH_RATE = 3'd3,
        PH_CHAN = 3'd4,
        PH_RESV = 3'd5,
        PH_DATA = 3'd6
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_RATE   = 2'd0;
    localparam logic [1:0] KIND_CHAN   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_LEN_DIGIT  = 2'd0;
    localparam logic [1:0] ERR_SIZE_DIGIT = 2'd1;
    localparam logic [1:0] ERR_SIZE_SHORT = 2'd2;

    // Framing characters
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_FIVE = 8'h35;
    localparam logic [7:0] CH_SIX  = 8'h36;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Header bytes counted in the block size
    localparam logic [19:0] HEADER_BYTES = 20'd8;

    // One result item
    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        rate_bits;
        logic [7:0]         channel_code;
        logic signed [15:0] sample;
        logic               last_in_block;
        logic [1:0]         error_code;
    } t_result;

endpackage

@@ rtl/core/scope_waveform_block_deframer.sv @@
// Top level: input register, block parser and output register.
// A byte accepted into the input register gives its result at o_valid from the output register.
// Throughput: one byte per cycle while i_stall is low; the input and output registers each take
// a new request whenever the next stage is moving, so back-to-back bytes flow without gaps.
// Bytes that cause no result pass through and leave the output register unchanged.
// Reset (synchronous, active low) empties both registers and returns the parser to hunting.
`timescale 1ns / 1ps

module scope_waveform_block_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [31:0]        o_rate_bits,
    output logic [7:0]         o_channel_code,
    output logic signed [15:0] o_sample,
    output logic               o_last_in_block,
    output logic [1:0]         o_error_code
);
    import swbd_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;

    logic       advance;
    logic       res_vld;
    t_result    res;

    // Process the held byte when the output register can take a request
    assign advance = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    swbd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_byte    (r_in_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // Output register: load a new result, drop a taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && res_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_vld) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_kind          = r_out.kind;
    assign o_rate_bits     = r_out.rate_bits;
    assign o_channel_code  = r_out.channel_code;
    assign o_sample        = r_out.sample;
    assign o_last_in_block = r_out.last_in_block;
    assign o_error_code    = r_out.error_code;

endmodule

@@ rtl/core/swbd_parser.sv @@
// Block parser: phase state and the per-byte update that forms results.
`timescale 1ns / 1ps

module swbd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    output logic             o_res_vld,
    output swbd_pkg::t_result o_res
);
    import swbd_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_digits, n_digits;
    logic [19:0] r_size,   n_size;
    logic [19:0] r_bytes,  n_bytes;
    logic [23:0] r_rate,   n_rate;
    logic [7:0]  r_high,   n_high;

    logic [19:0] acc;
    logic [19:0] bytes_dec;
    logic [2:0]  digits_dec;

    // Size times ten plus the new digit, wrapping at 20 bits
    assign acc = {r_size[16:0], 3'b000} + {r_size[18:0], 1'b0} + {16'd0, i_byte[3:0]};
    assign bytes_dec  = r_bytes - 20'd1;
    assign digits_dec = r_digits - 3'd1;

    // Advance the parser by one byte
    always_comb begin
        n_phase   = r_phase;
        n_digits  = r_digits;
        n_size    = r_size;
        n_bytes   = r_bytes;
        n_rate    = r_rate;
        n_high    = r_high;
        o_res_vld = 1'b0;
        o_res     = '0;
        case (r_phase)
            PH_LEN: begin
                if (i_byte inside {CH_FOUR, CH_FIVE, CH_SIX}) begin
                    n_digits = i_byte[2:0];
                    n_size   = '0;
                    n_phase  = PH_SIZE;
                end else begin
                    o_res_vld        = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_LEN_DIGIT;
                    n_phase          = PH_HUNT;
                end
            end
            PH_SIZE: begin
                if (!(i_byte inside {[CH_ZERO:CH_NINE]})) begin
                    o_res_vld        = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_SIZE_DIGIT;
                    n_phase          = PH_HUNT;
                end else begin
                    n_size   = acc;
                    n_digits = digits_dec;
                    if (digits_dec == 3'd0) begin
                        if (acc < HEADER_BYTES) begin
                            o_res_vld        = 1'b1;
                            o_res.kind       = KIND_ERROR;
                            o_res.error_code = ERR_SIZE_SHORT;
                            n_phase          = PH_HUNT;
                        end else begin
                            n_bytes = acc - HEADER_BYTES;
                            n_rate  = '0;
                            n_phase = PH_RATE;
                        end
                    end
                end
            end
            PH_RATE: begin
                if (r_digits < 3'd3) begin
                    n_rate   = {r_rate[15:0], i_byte};
                    n_digits = r_digits + 3'd1;
                end else begin
                    o_res_vld       = 1'b1;
                    o_res.kind      = KIND_RATE;
                    o_res.rate_bits = {r_rate, i_byte};
                    n_digits        = '0;
                    n_phase         = PH_CHAN;
                end
            end
            PH_CHAN: begin
                o_res_vld          = 1'b1;
                o_res.kind         = KIND_CHAN;
                o_res.channel_code = i_byte;
                n_digits           = 3'd3;
                n_phase            = PH_RESV;
            end
            PH_RESV: begin
                n_digits = digits_dec;
                if (digits_dec == 3'd0) begin
                    n_phase = (r_bytes == 20'd0) ? PH_HUNT : PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_digits == 3'd0) begin
                    // Drop a lone trailing byte, else hold the high byte
                    if (r_bytes <= 20'd1) begin
                        n_bytes = '0;
                        n_phase = PH_HUNT;
                    end else begin
                        n_high   = i_byte;
                        n_digits = 3'd1;
                        n_bytes  = bytes_dec;
                    end
                end else begin
                    n_bytes             = bytes_dec;
                    n_digits            = '0;
                    o_res_vld           = 1'b1;
                    o_res.kind          = KIND_SAMPLE;
                    o_res.sample        = {r_high, i_byte};
                    o_res.last_in_block = (bytes_dec < 20'd2);
                    if (bytes_dec == 20'd0) begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            default: begin
                n_phase = (i_byte == CH_HASH) ? PH_LEN : PH_HUNT;
            end
        endcase
    end

    // Update state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_digits <= '0;
            r_size   <= '0;
            r_bytes  <= '0;
            r_rate   <= '0;
            r_high   <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_size   <= n_size;
            r_bytes  <= n_bytes;
            r_rate   <= n_rate;
            r_high   <= n_high;
        end
    end

    // Channel byte always leads into three reserved bytes
    a_chan_to_resv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_CHAN) |=> (r_phase == PH_RESV && r_digits == 3'd3))
        else $error("channel byte did not start reserved bytes");

    // A high byte is held whenever more than one data byte remains
    a_pair_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_DATA && r_digits == 3'd0 && r_bytes > 20'd1)
        |=> (r_phase == PH_DATA && r_digits == 3'd1))
        else $error("sample high byte not held");

    // State moves only on a processed byte
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_phase) && $stable(r_bytes)))
        else $error("parser state changed without a byte");

endmodule
